// ----- rtl/prrb_pkg.sv -----
`default_nettype none
package prrb_pkg;

	localparam int unsigned SLOTS_DEF = 32;
	localparam int unsigned PNUM_W = 16;
	localparam int unsigned PK_W = 12;
	localparam int unsigned CNT_W = 16;
	localparam int unsigned POS_W = 6;
	localparam int unsigned ACT_W = 3;
	localparam int unsigned ST_W = 3;

	localparam logic [PNUM_W-1:0] PNUM_MAX_RST = 16'hFFFF;
	localparam logic [CNT_W-1:0] WLIMIT_RST = 16'd1024;

	// configuration register indexes
	localparam logic [0:0] REG_PNUM_MAX = 1'b0;
	localparam logic [0:0] REG_WLIMIT = 1'b1;

	typedef enum logic [ACT_W-1:0] {
		ACT_CLAIM = 3'd0,
		ACT_UPDATE = 3'd1,
		ACT_RELEASE = 3'd2,
		ACT_SEEK = 3'd3,
		ACT_RETIRE = 3'd4
	} action_t;

	localparam logic [ST_W-1:0] ST_IDLE = 3'd0;
	localparam logic [ST_W-1:0] ST_PENDING = 3'd1;
	localparam logic [ST_W-1:0] ST_PROGRESS = 3'd2;
	localparam logic [ST_W-1:0] ST_COMPLETE = 3'd3;
	localparam logic [ST_W-1:0] ST_ERROR = 3'd4;
	localparam logic [ST_W-1:0] ST_IGNORE = 3'd5;

	typedef struct packed {
		logic [ACT_W-1:0] action;
		logic [PNUM_W-1:0] payload_number;
		logic [ST_W-1:0] new_state;
		logic [PK_W-1:0] packets_added;
	} in_item_t;

	typedef struct packed {
		logic kind;
		logic [PNUM_W-1:0] released_number;
		logic released_as_error;
		logic [PK_W-1:0] released_packets;
		logic [POS_W-1:0] slot_index;
		logic newly_claimed;
		logic window_flushed;
		logic flush_failed;
		logic [POS_W-1:0] current_position;
		logic [CNT_W-1:0] buffered_packets;
		logic last;
	} out_item_t;

	typedef enum logic [2:0] {
		EX_IDLE,
		EX_READ,
		EX_WALK,
		EX_FLUSH,
		EX_SEEK,
		EX_STATUS
	} ex_state_t;

endpackage
`default_nettype wire

// ----- rtl/prrb_ram.sv -----
`default_nettype none
module prrb_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 32
) (
	input wire logic clk,
	input wire logic we,
	input wire logic [$clog2(DEPTH)-1:0] waddr,
	input wire logic [WIDTH-1:0] wdata,
	input wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0] rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	// one write port, registered read
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule
`default_nettype wire

// ----- rtl/prrb_fifo.sv -----
`default_nettype none
module prrb_fifo #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 2
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic push,
	input wire logic [WIDTH-1:0] wdata,
	output logic full,
	input wire logic pop,
	output logic [WIDTH-1:0] rdata,
	output logic empty
);
	localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	logic [WIDTH-1:0] buf_q [DEPTH];
	logic [AW-1:0] wp_q, rp_q;
	logic [AW:0] cnt_q;
	logic do_push, do_pop;

	assign full = (cnt_q == (AW+1)'(DEPTH));
	assign empty = (cnt_q == '0);
	assign do_push = push && !full;
	assign do_pop = pop && !empty;
	assign rdata = buf_q[rp_q];

	// storage
	always_ff @(posedge clk) begin
		if (do_push) begin
			buf_q[wp_q] <= wdata;
		end
	end

	// pointers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0;
			rp_q <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) begin
				wp_q <= (wp_q == AW'(DEPTH-1)) ? '0 : wp_q + 1'b1;
			end
			if (do_pop) begin
				rp_q <= (rp_q == AW'(DEPTH-1)) ? '0 : rp_q + 1'b1;
			end
			cnt_q <= cnt_q + (AW+1)'(do_push) - (AW+1)'(do_pop);
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n) full |-> !empty)
		else $error("fifo full and empty");
	assert property (@(posedge clk) disable iff (!arst_n) cnt_q <= (AW+1)'(DEPTH))
		else $error("fifo count overflow");
	assert property (@(posedge clk) disable iff (!arst_n)
		(do_push && !do_pop) |=> !empty)
		else $error("fifo lost push");
endmodule
`default_nettype wire

// ----- rtl/prrb_engine.sv -----
`default_nettype none
module prrb_engine #(
	parameter int unsigned SLOTS = prrb_pkg::SLOTS_DEF
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic cmd_valid,
	input wire prrb_pkg::in_item_t cmd,
	output logic cmd_take,
	input wire logic [prrb_pkg::PNUM_W-1:0] pnum_max,
	input wire logic [prrb_pkg::CNT_W-1:0] wlimit,
	output logic res_push,
	output prrb_pkg::out_item_t res,
	input wire logic res_full,
	output logic busy
);
	import prrb_pkg::*;

	localparam int unsigned IW = $clog2(SLOTS);
	localparam int unsigned SW = $clog2(SLOTS + 1);
	localparam int unsigned RW = ST_W + PNUM_W + PK_W;

	ex_state_t state_q, state_d;
	in_item_t cmd_q;
	logic [SLOTS-1:0] used_q;
	logic [POS_W-1:0] wstart_q;
	logic [CNT_W-1:0] bcount_q;
	logic [IW-1:0] idx_q;
	logic [SW-1:0] steps_q;
	logic [IW:0] start_q;
	logic flushed_q, failed_q, found_q, wstart_in_q;

	// slot record ram
	logic ram_we;
	logic [IW-1:0] ram_waddr, ram_raddr;
	logic [RW-1:0] ram_wdata, ram_rdata;
	logic byp_q;
	logic [RW-1:0] byp_data_q, rd_word;
	logic [ST_W-1:0] r_st;
	logic [PNUM_W-1:0] r_num;
	logic [PK_W-1:0] r_pk;

	prrb_ram #(.WIDTH(RW), .DEPTH(SLOTS)) u_ram (
		.clk(clk), .we(ram_we), .waddr(ram_waddr), .wdata(ram_wdata),
		.raddr(ram_raddr), .rdata(ram_rdata)
	);
	assign rd_word = byp_q ? byp_data_q : ram_rdata;
	assign {r_st, r_num, r_pk} = rd_word;

	// write-to-read bypass for a slot read in the cycle it is written
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byp_q <= 1'b0;
			byp_data_q <= '0;
		end else begin
			byp_q <= ram_we && (ram_waddr == ram_raddr);
			byp_data_q <= ram_wdata;
		end
	end

	// decoded helpers
	logic [IW-1:0] slot;
	logic [IW:0] top;
	logic [IW:0] adv_idx;
	logic [IW-1:0] nidx;
	logic sendable, flush_mark, flush_send, count_hi, count_hi_after, ready_slot;
	logic [CNT_W-1:0] after_cnt;
	logic [PK_W:0] pk_sum;
	logic [CNT_W:0] cnt_sum;

	assign slot = cmd_q.payload_number[IW-1:0];
	assign top = (pnum_max < PNUM_W'(SLOTS - 1)) ? pnum_max[IW:0] : (IW+1)'(SLOTS - 1);

	// advance with wrap at the lesser of max and last slot
	always_comb begin
		adv_idx = {1'b0, idx_q} + 1'b1;
		if (adv_idx > top) begin
			adv_idx = '0;
		end
		nidx = adv_idx[IW-1:0];
	end

	assign ready_slot = used_q[idx_q];
	assign sendable = ready_slot && (r_st == ST_COMPLETE || r_st == ST_ERROR);
	assign flush_mark = ready_slot && (r_st == ST_PENDING || r_st == ST_PROGRESS);
	assign flush_send = sendable || flush_mark;
	assign after_cnt = (bcount_q >= CNT_W'(r_pk)) ? bcount_q - CNT_W'(r_pk) : '0;
	assign count_hi = (bcount_q >= wlimit);
	assign count_hi_after = ((((state_q == EX_WALK) ? sendable : flush_send)
		? after_cnt : bcount_q) >= wlimit);
	assign pk_sum = {1'b0, r_pk} + {1'b0, cmd_q.packets_added};
	assign cnt_sum = {1'b0, bcount_q} + (CNT_W+1)'(cmd_q.packets_added);

	logic walk_end, flush_end;
	assign walk_end = !sendable || (steps_q == SW'(SLOTS - 1));
	assign flush_end = ({1'b0, nidx} == start_q) || (steps_q == SW'(SLOTS - 1));

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			EX_IDLE: begin
				if (cmd_valid) begin
					state_d = EX_READ;
				end
			end
			EX_READ: begin
				case (cmd_q.action)
					ACT_CLAIM, ACT_UPDATE, ACT_RETIRE: state_d = EX_STATUS;
					ACT_RELEASE: state_d = (wstart_in_q) ? EX_WALK
						: (count_hi ? EX_FLUSH : EX_STATUS);
					ACT_SEEK: state_d = EX_SEEK;
					default: state_d = EX_STATUS;
				endcase
			end
			EX_WALK: begin
				if (!(sendable && res_full)) begin
					if (walk_end) begin
						state_d = count_hi_after ? EX_FLUSH : EX_STATUS;
					end
				end
			end
			EX_FLUSH: begin
				if (!(flush_send && res_full)) begin
					if (!count_hi_after || flush_end) begin
						state_d = EX_STATUS;
					end
				end
			end
			EX_SEEK: begin
				if (ready_slot || steps_q == SW'(SLOTS - 1) || {1'b0, nidx} == start_q) begin
					state_d = EX_STATUS;
				end
			end
			EX_STATUS: begin
				if (!res_full) begin
					state_d = EX_IDLE;
				end
			end
			default: state_d = EX_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		cmd_take = (state_q == EX_IDLE) && cmd_valid;
		busy = (state_q != EX_IDLE);
		ram_raddr = idx_q;
		ram_we = 1'b0;
		ram_waddr = idx_q;
		ram_wdata = ram_rdata;
		res_push = 1'b0;
		res = '0;
		res.current_position = wstart_q;
		res.buffered_packets = bcount_q;
		if (state_q == EX_IDLE) begin
			ram_raddr = cmd.payload_number[IW-1:0];
		end else if (state_q == EX_WALK || state_q == EX_FLUSH || state_q == EX_SEEK) begin
			ram_raddr = nidx;
		end
		case (state_q)
			EX_READ: begin
				ram_waddr = slot;
				if (cmd_q.action == ACT_CLAIM && !used_q[slot]) begin
					ram_we = 1'b1;
					ram_wdata = {ST_IDLE, cmd_q.payload_number, PK_W'(0)};
				end else if (cmd_q.action == ACT_UPDATE && used_q[slot]) begin
					ram_we = 1'b1;
					ram_wdata = {cmd_q.new_state, r_num,
						pk_sum[PK_W] ? {PK_W{1'b1}} : pk_sum[PK_W-1:0]};
				end
			end
			EX_WALK, EX_FLUSH: begin
				if ((state_q == EX_WALK ? sendable : flush_send) && !res_full) begin
					res_push = 1'b1;
					res.released_number = r_num;
					res.released_as_error = (r_st != ST_COMPLETE);
					res.released_packets = r_pk;
					res.slot_index = POS_W'(idx_q);
					res.window_flushed = (state_q == EX_FLUSH);
					res.current_position = POS_W'(nidx);
					res.buffered_packets = after_cnt;
					ram_we = (r_st != ST_COMPLETE);
					ram_wdata = {ST_IGNORE, r_num, PK_W'(0)};
				end else if (state_q == EX_FLUSH && ready_slot && r_st != ST_COMPLETE
					&& r_st != ST_ERROR && !flush_send) begin
					ram_we = 1'b0;
				end
				// stalled or walk over: hold read address on current slot
				if (state_q == EX_WALK ? (!sendable || res_full) : (flush_send && res_full)) begin
					ram_raddr = idx_q;
				end
			end
			EX_STATUS: begin
				res_push = !res_full;
				res.kind = 1'b1;
				res.last = 1'b1;
				res.newly_claimed = found_q && cmd_q.action == ACT_CLAIM;
				res.window_flushed = flushed_q;
				res.flush_failed = failed_q;
				res.slot_index = (cmd_q.action == ACT_CLAIM || cmd_q.action == ACT_UPDATE
					|| cmd_q.action == ACT_RETIRE) ? POS_W'(slot) : wstart_q;
			end
			default: ;
		endcase
	end

	// control and slot state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= EX_IDLE;
			used_q <= '0;
			wstart_q <= '0;
			bcount_q <= '0;
			idx_q <= '0;
			steps_q <= '0;
			start_q <= '0;
			flushed_q <= 1'b0;
			failed_q <= 1'b0;
			found_q <= 1'b0;
			wstart_in_q <= 1'b0;
			cmd_q <= '0;
		end else begin
			state_q <= state_d;
			case (state_q)
				EX_IDLE: begin
					cmd_q <= cmd;
					flushed_q <= 1'b0;
					failed_q <= 1'b0;
					found_q <= 1'b0;
					steps_q <= '0;
					// the walk only starts inside the table
					wstart_in_q <= ({1'b0, wstart_q} < (POS_W+1)'(SLOTS));
					idx_q <= (cmd.action == ACT_CLAIM || cmd.action == ACT_UPDATE
						|| cmd.action == ACT_RETIRE) ? cmd.payload_number[IW-1:0]
						: wstart_q[IW-1:0];
					start_q <= (IW+1)'(wstart_q);
				end
				EX_READ: begin
					case (cmd_q.action)
						ACT_CLAIM: begin
							if (!used_q[slot]) begin
								used_q[slot] <= 1'b1;
								found_q <= 1'b1;
							end
						end
						ACT_UPDATE: begin
							if (used_q[slot]) begin
								bcount_q <= cnt_sum[CNT_W] ? {CNT_W{1'b1}} : cnt_sum[CNT_W-1:0];
							end
						end
						ACT_RETIRE: used_q[slot] <= 1'b0;
						ACT_RELEASE: begin
							if (!wstart_in_q && count_hi) begin
								// out-of-range start: flush sees nothing, laps
								flushed_q <= 1'b1;
								failed_q <= 1'b1;
							end else if (!wstart_in_q) begin
								flushed_q <= 1'b0;
							end
						end
						default: ;
					endcase
				end
				EX_WALK: begin
					if (!(sendable && res_full)) begin
						if (sendable) begin
							bcount_q <= after_cnt;
							wstart_q <= POS_W'(nidx);
							if (r_st == ST_COMPLETE) begin
								used_q[idx_q] <= 1'b0;
							end
						end
						if (walk_end) begin
							// flush starts from the window start
							idx_q <= sendable ? nidx : idx_q;
							start_q <= sendable ? {1'b0, nidx} : {1'b0, idx_q};
							steps_q <= '0;
							flushed_q <= count_hi_after;
						end else begin
							idx_q <= nidx;
							steps_q <= steps_q + 1'b1;
						end
					end
				end
				EX_FLUSH: begin
					flushed_q <= 1'b1;
					if (!(flush_send && res_full)) begin
						if (flush_send) begin
							bcount_q <= after_cnt;
							wstart_q <= POS_W'(nidx);
							if (r_st == ST_COMPLETE) begin
								used_q[idx_q] <= 1'b0;
							end
						end
						if (count_hi_after && flush_end) begin
							failed_q <= 1'b1;
						end
						idx_q <= nidx;
						steps_q <= steps_q + 1'b1;
					end
				end
				EX_SEEK: begin
					if (ready_slot) begin
						wstart_q <= POS_W'(idx_q);
					end else begin
						idx_q <= nidx;
						steps_q <= steps_q + 1'b1;
					end
				end
				default: ;
			endcase
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n) res_push |-> !res_full)
		else $error("result pushed into full queue");
	assert property (@(posedge clk) disable iff (!arst_n)
		(res_push && res.kind) |=> (state_q == EX_IDLE))
		else $error("status not final");
	assert property (@(posedge clk) disable iff (!arst_n) cmd_take |=> (state_q == EX_READ))
		else $error("item not started");
endmodule
`default_nettype wire

// ----- rtl/payload_reorder_release_buffer.sv -----
`default_nettype none
// channel  | direction | handshake          | payload
// in       | input     | push / full        | in_item (action, number, state, packets)
// result   | output    | empty / pop        | out_item (one per release, then status)
// cfg      | input     | cfg_valid/cfg_ready| cfg_index, cfg_data
// Claim, update, retire: take and slot read, then write, then status.
// Release walks one slot a cycle, then flushes one a cycle while at or over the window limit.
// Seek scans one slot a cycle, over at most SLOTS slots.
// The slot record memory has one read and one write port; it sets the walk rate.
// Reset is asynchronous; slot records are undefined until claimed.
// A full result queue stalls the walk in place; input queue accepts until full.
module payload_reorder_release_buffer #(
	parameter int unsigned SLOTS = prrb_pkg::SLOTS_DEF
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic push,
	output logic full,
	input wire prrb_pkg::in_item_t in_item,
	output logic empty,
	input wire logic pop,
	output prrb_pkg::out_item_t out_item,
	input wire logic cfg_valid,
	output logic cfg_ready,
	input wire logic [0:0] cfg_index,
	input wire logic [15:0] cfg_data
);
	import prrb_pkg::*;

	logic [PNUM_W-1:0] pnum_max_q;
	logic [CNT_W-1:0] wlimit_q;
	logic cq_empty, cmd_take, res_push, res_full, busy;
	in_item_t cq_data;
	out_item_t res;

	assign cfg_ready = 1'b1;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pnum_max_q <= PNUM_MAX_RST;
			wlimit_q <= WLIMIT_RST;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_PNUM_MAX: pnum_max_q <= cfg_data;
				REG_WLIMIT: wlimit_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// front: input queue
	prrb_fifo #(.WIDTH($bits(in_item_t)), .DEPTH(2)) u_in_q (
		.clk(clk), .arst_n(arst_n), .push(push), .wdata(in_item), .full(full),
		.pop(cmd_take), .rdata(cq_data), .empty(cq_empty)
	);

	// back: slot engine
	prrb_engine #(.SLOTS(SLOTS)) u_engine (
		.clk(clk), .arst_n(arst_n), .cmd_valid(!cq_empty), .cmd(cq_data),
		.cmd_take(cmd_take), .pnum_max(pnum_max_q), .wlimit(wlimit_q),
		.res_push(res_push), .res(res), .res_full(res_full), .busy(busy)
	);

	// result queue
	prrb_fifo #(.WIDTH($bits(out_item_t)), .DEPTH(2)) u_out_q (
		.clk(clk), .arst_n(arst_n), .push(res_push), .wdata(res), .full(res_full),
		.pop(pop), .rdata(out_item), .empty(empty)
	);

	assert property (@(posedge clk) disable iff (!arst_n) cmd_take |-> !cq_empty)
		else $error("take from empty queue");
	assert property (@(posedge clk) disable iff (!arst_n) cmd_take |-> !busy)
		else $error("take while busy");
	assert property (@(posedge clk) disable iff (!arst_n) res_push |-> !res_full)
		else $error("result overflow");
endmodule
`default_nettype wire

// ----- bench/tb_top.sv -----
`default_nettype none
module tb_top;
	import prrb_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned NSLOT = SLOTS_DEF;
	localparam int unsigned DRAIN_CYCLES = 2 * NSLOT + 40;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic push = 1'b0;
	logic full;
	in_item_t in_item = '0;
	logic empty;
	logic pop = 1'b0;
	out_item_t out_item;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [0:0] cfg_index = REG_PNUM_MAX;
	logic [15:0] cfg_data = '0;

	payload_reorder_release_buffer DUT (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.full(full),
		.in_item(in_item),
		.empty(empty),
		.pop(pop),
		.out_item(out_item),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	// shadow copy of the reorder table
	bit slot_busy [NSLOT];
	logic [ST_W-1:0] slot_st [NSLOT];
	logic [PNUM_W-1:0] slot_num [NSLOT];
	logic [PK_W-1:0] slot_pk [NSLOT];
	int unsigned win_start = 0;
	int unsigned buf_count = 0;
	int unsigned lim_pnum_max = PNUM_MAX_RST;
	int unsigned lim_window = WLIMIT_RST;

	in_item_t item_backlog [$];
	out_item_t due_results [$];
	int errors = 0;
	bit calm = 1'b0;
	int hold_trigger = 0;
	int hold_seen = 0;
	int hold_left = 0;
	int base_num = 0;

	initial begin
		forever #4 clk = ~clk;
	end

	initial begin
		#5_000_000;
		$display("TB_ERROR");
		$finish;
	end

	function automatic int unsigned next_index(int unsigned i);
		int unsigned top;
		top = (lim_pnum_max < NSLOT - 1) ? lim_pnum_max : NSLOT - 1;
		i++;
		if (i > top) i = 0;
		return i;
	endfunction

	function automatic void note_result(bit k, logic [15:0] num, bit err, logic [11:0] pkc,
			int unsigned slot, bit cl, bit fl, bit fa);
		out_item_t r;
		r.kind = k;
		r.released_number = num;
		r.released_as_error = err;
		r.released_packets = pkc;
		r.slot_index = slot[5:0];
		r.newly_claimed = cl;
		r.window_flushed = fl;
		r.flush_failed = fa;
		r.current_position = win_start[5:0];
		r.buffered_packets = buf_count[15:0];
		r.last = k;
		due_results.push_back(r);
	endfunction

	// release a complete or error payload at idx
	function automatic bit release_slot(int unsigned idx, bit fl, inout int n);
		logic [ST_W-1:0] st;
		logic [11:0] pkc;
		if (idx >= NSLOT || !slot_busy[idx] || n >= NSLOT) return 0;
		st = slot_st[idx];
		if (st != ST_COMPLETE && st != ST_ERROR) return 0;
		pkc = slot_pk[idx];
		buf_count = (buf_count >= pkc) ? buf_count - pkc : 0;
		if (st == ST_COMPLETE) begin
			slot_busy[idx] = 0;
		end else begin
			slot_st[idx] = ST_IGNORE;
			slot_pk[idx] = '0;
		end
		win_start = next_index(idx);
		note_result(0, slot_num[idx], st == ST_ERROR, pkc, idx, 0, fl, 0);
		n++;
		return 1;
	endfunction

	function automatic void predict_table_item(in_item_t it);
		int unsigned slot, idx, steps, first, sum;
		int n;
		bit claimed, flushed, failed, found;
		int unsigned status_slot;
		slot = it.payload_number % NSLOT;
		status_slot = slot;
		n = 0;
		claimed = 0;
		flushed = 0;
		failed = 0;
		case (it.action)
			ACT_CLAIM: begin
				if (!slot_busy[slot]) begin
					slot_busy[slot] = 1;
					slot_st[slot] = ST_IDLE;
					slot_num[slot] = it.payload_number;
					slot_pk[slot] = '0;
					claimed = 1;
				end
			end
			ACT_UPDATE: begin
				if (slot_busy[slot]) begin
					sum = slot_pk[slot] + it.packets_added;
					slot_st[slot] = it.new_state;
					slot_pk[slot] = (sum > 4095) ? 12'd4095 : sum[11:0];
					buf_count += it.packets_added;
					if (buf_count > 65535) buf_count = 65535;
				end
			end
			ACT_RELEASE: begin
				idx = win_start;
				steps = 0;
				while (steps < NSLOT && release_slot(idx, 0, n)) begin
					idx = next_index(idx);
					steps++;
				end
				if (buf_count >= lim_window) begin
					flushed = 1;
					idx = win_start;
					first = idx;
					steps = 0;
					while (buf_count >= lim_window) begin
						if (idx < NSLOT && slot_busy[idx]) begin
							if (slot_st[idx] == ST_PENDING || slot_st[idx] == ST_PROGRESS)
								slot_st[idx] = ST_ERROR;
							void'(release_slot(idx, 1, n));
						end
						idx = next_index(idx);
						steps++;
						if (idx == first || steps >= NSLOT) begin
							if (buf_count >= lim_window) failed = 1;
							break;
						end
					end
				end
				status_slot = win_start;
			end
			ACT_SEEK: begin
				idx = win_start;
				steps = 0;
				found = 0;
				while (steps < NSLOT) begin
					if (idx < NSLOT && slot_busy[idx]) begin
						found = 1;
						break;
					end
					idx = next_index(idx);
					steps++;
					if (idx == win_start) break;
				end
				if (found) win_start = idx;
				status_slot = win_start;
			end
			ACT_RETIRE: slot_busy[slot] = 0;
			default: status_slot = win_start;
		endcase
		note_result(1, '0, 0, '0, status_slot, claimed, flushed, failed);
	endfunction

	// input side: offer backlog items, predict on each accepted transaction
	always @(posedge clk) begin
		if (arst_n) begin
			if (push && !full) predict_table_item(in_item);
			if ((!push || !full) && item_backlog.size() != 0
					&& (calm || $urandom_range(99) >= 26)) begin
				in_item <= item_backlog.pop_front();
				push <= 1'b1;
			end else if (!push || !full) begin
				push <= 1'b0;
			end
		end
	end

	// long receiver hold-off counter
	always @(posedge clk) begin
		if (hold_trigger != hold_seen) begin
			hold_seen <= hold_trigger;
			hold_left <= 400;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
		end
	end

	// result side: check each transaction against the oldest expectation
	always @(posedge clk) begin
		out_item_t want;
		if (arst_n) begin
			if (pop && !empty) begin
				if (due_results.size() == 0) begin
					errors++;
					if (errors <= 10) $display("unexpected result %p", out_item);
				end else begin
					want = due_results.pop_front();
					if (out_item.kind !== want.kind
							|| out_item.released_number !== want.released_number
							|| out_item.released_as_error !== want.released_as_error
							|| out_item.released_packets !== want.released_packets
							|| out_item.slot_index !== want.slot_index
							|| out_item.newly_claimed !== want.newly_claimed
							|| out_item.window_flushed !== want.window_flushed
							|| out_item.flush_failed !== want.flush_failed
							|| out_item.current_position !== want.current_position
							|| out_item.buffered_packets !== want.buffered_packets
							|| out_item.last !== want.last) begin
						errors++;
						if (errors <= 10)
							$display("mismatch: expected %p actual %p", want, out_item);
					end
				end
			end
			pop <= (hold_left == 0) && (calm || $urandom_range(99) >= 26);
		end
	end

	task automatic add_item(logic [2:0] act, logic [15:0] num, logic [2:0] st,
			logic [11:0] pkc);
		in_item_t it;
		it.action = act;
		it.payload_number = num;
		it.new_state = st;
		it.packets_added = pkc;
		item_backlog.push_back(it);
	endtask

	task automatic wait_drained();
		while (item_backlog.size() != 0 || push || due_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(logic [0:0] idx, logic [15:0] val);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 1'b0;
		if (idx == REG_PNUM_MAX) lim_pnum_max = 32'(val);
		else lim_window = 32'(val);
	endtask

	// mostly well-formed claim / update / release / seek / retire sequences around a moving base
	task automatic add_random(int count);
		int sel;
		logic [15:0] num;
		logic [2:0] st;
		logic [11:0] pkc;
		repeat (count) begin
			sel = $urandom_range(99);
			if ($urandom_range(9) == 0) num = 16'($urandom);
			else num = 16'(base_num + $urandom_range(12));
			if ($urandom_range(7) == 0) st = 3'($urandom_range(7));
			else st = 3'($urandom_range(4, 1));
			case ($urandom_range(9))
				0: pkc = 12'd4095;
				1: pkc = 12'($urandom);
				default: pkc = 12'($urandom_range(300));
			endcase
			if (sel < 25) begin
				add_item(ACT_CLAIM, num, 3'($urandom), 12'($urandom));
			end else if (sel < 60) begin
				add_item(ACT_UPDATE, num, st, pkc);
			end else if (sel < 80) begin
				add_item(ACT_RELEASE, 16'($urandom), 3'($urandom), 12'($urandom));
				base_num += $urandom_range(6);
			end else if (sel < 87) begin
				add_item(ACT_SEEK, 16'($urandom), 3'($urandom), 12'($urandom));
			end else if (sel < 95) begin
				add_item(ACT_RETIRE, num, 3'($urandom), 12'($urandom));
			end else begin
				add_item(3'($urandom_range(7, 5)), 16'($urandom), 3'($urandom),
					12'($urandom));
			end
		end
	endtask

	initial begin
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		// directed: claims, saturation, flush with failed lap, odd codes
		add_item(ACT_CLAIM, 16'd5, ST_IDLE, 12'd0);
		add_item(ACT_CLAIM, 16'd37, ST_IDLE, 12'd0);
		add_item(ACT_UPDATE, 16'd6, ST_COMPLETE, 12'd9);
		add_item(ACT_UPDATE, 16'd5, ST_PROGRESS, 12'd4095);
		add_item(ACT_UPDATE, 16'd5, ST_COMPLETE, 12'd4095);
		add_item(ACT_CLAIM, 16'hFFFF, ST_IDLE, 12'd0);
		add_item(ACT_UPDATE, 16'hFFFF, ST_ERROR, 12'd1);
		add_item(ACT_RELEASE, 16'd0, 3'd0, 12'd0);
		add_item(ACT_SEEK, 16'd0, 3'd0, 12'd0);
		add_item(ACT_RELEASE, 16'd0, 3'd0, 12'd0);
		add_item(ACT_UPDATE, 16'hFFFF, 3'd7, 12'd0);
		add_item(ACT_CLAIM, 16'd1, 3'd7, 12'hFFF);
		add_item(ACT_UPDATE, 16'd1, 3'd7, 12'd3);
		add_item(ACT_UPDATE, 16'd1, ST_IDLE, 12'd0);
		add_item(ACT_UPDATE, 16'd1, ST_IGNORE, 12'd2);
		add_item(ACT_UPDATE, 16'd1, 3'd6, 12'd2);
		add_item(ACT_RETIRE, 16'hFFFF, 3'd0, 12'd0);
		add_item(3'd5, 16'hFFFF, 3'd7, 12'hFFF);
		add_item(3'd6, 16'd0, 3'd0, 12'd0);
		add_item(3'd7, 16'hAAAA, 3'd5, 12'h555);
		add_item(ACT_RETIRE, 16'd1, 3'd0, 12'd0);
		add_item(ACT_SEEK, 16'd0, 3'd0, 12'd0);
		add_item(ACT_RELEASE, 16'd0, 3'd0, 12'd0);
		wait_drained();

		// tight wrap and a window limit of 1
		write_reg(REG_PNUM_MAX, 16'd0);
		write_reg(REG_WLIMIT, 16'd1);
		add_random(35);
		wait_drained();

		// widest settings, back-pressure with a long receiver hold-off
		write_reg(REG_PNUM_MAX, 16'hFFFF);
		write_reg(REG_WLIMIT, 16'hFFFF);
		calm = 1'b1;
		hold_trigger++;
		add_random(60);
		wait_drained();
		calm = 1'b0;

		// window start past the wrap limit, zero window limit
		write_reg(REG_PNUM_MAX, 16'd9);
		write_reg(REG_WLIMIT, 16'd0);
		add_random(35);
		wait_drained();

		write_reg(REG_PNUM_MAX, 16'd31);
		write_reg(REG_WLIMIT, 16'd500);
		add_random(35);
		wait_drained();

		if (errors == 0 && due_results.size() == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end
endmodule
`default_nettype wire
